// ===== rtl/shared_buffer_double_stack_defines.svh =====
// Assertion macros shared by the shared_buffer_double_stack RTL.
// Users need clk_i and rst_ni in scope where a macro is expanded.
`ifndef SHARED_BUFFER_DOUBLE_STACK_DEFINES_SVH
`define SHARED_BUFFER_DOUBLE_STACK_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define SBDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define SBDS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbds_pkg.sv =====
// Package for the shared-array double stack: sizes, payload structs, codes.
// Used by sbds_ctrl, sbds_dp and shared_buffer_double_stack.
`timescale 1ns / 1ps

package sbds_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_POP   = 1'b1;
  localparam logic STK_LOWER = 1'b0;
  localparam logic STK_UPPER = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                     action;
    logic                     which_stack;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
  } out_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_READ
  } fsm_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic emit_now;
    logic emit_pop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_ok;
  } stat_t;

endpackage

// ===== rtl/shared_buffer_double_stack.sv =====
// Two stacks in one 128-word array. A push or refused pop gives its result
// from the item register and then the result register; a successful pop
// also passes the registered memory read first. A new item is taken only
// while busy is low; busy is low again in the cycle the result shows.
// Reset (async, active low) empties both stacks; the array itself is not
// cleared. The receiver cannot stall: each result strobes done_o once.
`timescale 1ns / 1ps

module shared_buffer_double_stack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sbds_pkg::in_t  item_i,
  output sbds_pkg::out_t result_o,
  output logic           done_o
);
  import sbds_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sbds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sbds_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

// ===== rtl/sbds_ctrl.sv =====
// Sequencer for the double stack: accept, execute, optional memory read.
// Depends on sbds_pkg.
`timescale 1ns / 1ps

module sbds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sbds_pkg::stat_t stat_i,
  output sbds_pkg::cmd_t  cmd_o
);
  import sbds_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (start) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        state_d = stat_i.pop_ok ? FSM_READ : FSM_IDLE;
      end
      FSM_READ: begin
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      FSM_IDLE: begin
        busy        = 1'b0;
        cmd_o.latch = start;
      end
      FSM_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.emit_now = !stat_i.pop_ok;
      end
      FSM_READ: begin
        cmd_o.emit_pop = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/sbds_dp.sv =====
// Datapath for the double stack: item register, both tops, shared memory,
// result register. Depends on sbds_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "shared_buffer_double_stack_defines.svh"

module sbds_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbds_pkg::in_t   item_i,
  input  sbds_pkg::cmd_t  cmd_i,
  output sbds_pkg::stat_t stat_o,
  output sbds_pkg::out_t  result_o,
  output logic            done_o
);
  import sbds_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];

  in_t                      item_q;
  logic [CNT_W-1:0]         lower_q, lower_d;
  logic [CNT_W-1:0]         upper_q, upper_d;
  logic signed [DATA_W-1:0] rd_q;
  out_t                     res_q, res_d;
  logic                     done_q, done_d;

  logic                     is_push, sel_lower, full, empty_sel;
  logic [CNT_W-1:0]         lower_m1, upper_m1;
  status_e                  op_status;
  logic                     wr_en, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;

  always_comb begin
    is_push   = (item_q.action == ACT_PUSH);
    sel_lower = (item_q.which_stack == STK_LOWER);
    full      = (lower_q == upper_q);
    lower_m1  = lower_q - 1'b1;
    upper_m1  = upper_q - 1'b1;
    empty_sel = sel_lower ? (lower_q == '0) : (upper_q == DEPTH_C);
    if (is_push) begin
      op_status = full ? ST_FULL : ST_DONE;
    end else begin
      op_status = empty_sel ? ST_EMPTY : ST_DONE;
    end
    stat_o.pop_ok = !is_push && !empty_sel;
    wr_en   = cmd_i.exec && is_push && !full;
    rd_en   = cmd_i.exec && stat_o.pop_ok;
    wr_addr = sel_lower ? lower_q[ADDR_W-1:0] : upper_m1[ADDR_W-1:0];
    rd_addr = sel_lower ? lower_m1[ADDR_W-1:0] : upper_q[ADDR_W-1:0];
  end

  // Advance the named top only when the operation goes through
  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    if (cmd_i.exec && op_status == ST_DONE) begin
      case ({is_push, sel_lower})
        {ACT_PUSH == 1'b0, 1'b1}: lower_d = lower_q + 1'b1;
        {ACT_PUSH == 1'b0, 1'b0}: upper_d = upper_m1;
        {ACT_PUSH == 1'b1, 1'b1}: lower_d = lower_m1;
        default:                  upper_d = upper_q + 1'b1;
      endcase
    end
  end

  always_comb begin
    res_d  = res_q;
    done_d = cmd_i.emit_now || cmd_i.emit_pop;
    if (cmd_i.emit_now) begin
      res_d.popped_value = '0;
      res_d.status       = op_status;
    end else if (cmd_i.emit_pop) begin
      res_d.popped_value = rd_q;
      res_d.status       = ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= DEPTH_C;
      done_q  <= 1'b0;
    end else begin
      lower_q <= lower_d;
      upper_q <= upper_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= item_i;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= item_q.push_value;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign result_o = res_q;
  assign done_o   = done_q;

  `SBDS_ASSERT(a_tops_ordered, lower_q <= upper_q, "stack tops crossed")
  `SBDS_ASSERT(a_upper_bound, upper_q <= DEPTH_C, "upper top beyond array end")
  `SBDS_ASSERT_NEXT(a_pop_emits, rd_en, cmd_i.emit_pop, "pop read not followed by result")
  `SBDS_ASSERT_NEXT(a_single_strobe, done_q, !done_q, "result strobe held two cycles")

endmodule
